// File: rtl/modular_exponentiation_unit_assert.svh
// Assertion macros for the module that checks its own logic.
// Every check is sampled on the rising edge of clk and is off while rst is high.
`ifndef MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH
`define MODULAR_EXPONENTIATION_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mexp_pkg.sv
package mexp_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int CNT_W = $clog2(OPERAND_WIDTH);

  typedef logic [OPERAND_WIDTH-1:0] operand_t;

  // Operand selection for the shared modular multiplier.
  typedef enum logic [1:0] {
    OP_REDUCE = 2'd0,
    OP_ACC    = 2'd1,
    OP_SQ     = 2'd2
  } mul_op_t;

  typedef struct packed {
    logic    load;
    logic    clear_acc;
    logic    mul_start;
    mul_op_t mul_op;
    logic    wr_sq;
    logic    wr_acc;
    logic    shift_exp;
    logic    load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic mul_busy;
    logic exp_bit;
    logic last_bit;
    logic exp_zero;
    logic mod_zero;
  } dp_status_t;

endpackage

// File: rtl/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle, MSB first.
module mexp_mulmod import mexp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  operand_t mplier,
  input  operand_t mcand,
  input  operand_t modulus,
  output logic     busy,
  output logic     done,
  output operand_t product
);

  logic [CNT_W-1:0]         cnt;
  operand_t                 a_sh;
  operand_t                 x_q;
  operand_t                 r;
  operand_t                 r_next;
  operand_t                 addend;
  logic [OPERAND_WIDTH+1:0] t;
  logic [OPERAND_WIDTH+1:0] m1;
  logic [OPERAND_WIDTH+1:0] m2;
  logic [OPERAND_WIDTH+1:0] d1;
  logic [OPERAND_WIDTH+1:0] d2;

  // The partial result stays below the modulus, so 2r + x is below three times
  // the modulus and one of three candidates is the reduced value.
  always_comb begin
    addend = a_sh[OPERAND_WIDTH-1] ? x_q : '0;
    t      = {1'b0, r, 1'b0} + {2'b00, addend};
    m1     = {2'b00, modulus};
    m2     = {1'b0, modulus, 1'b0};
    d1     = t - m1;
    d2     = t - m2;
    if (t >= m2) begin
      r_next = d2[OPERAND_WIDTH-1:0];
    end else if (t >= m1) begin
      r_next = d1[OPERAND_WIDTH-1:0];
    end else begin
      r_next = t[OPERAND_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(OPERAND_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sh <= mplier;
      x_q  <= mcand;
      r    <= '0;
    end else if (busy) begin
      a_sh <= a_sh << 1;
      r    <= r_next;
    end
  end

  assign product = r;

endmodule

// File: rtl/mexp_datapath.sv
// Operand registers, exponent shifter, output register and the shared multiplier.
module mexp_datapath import mexp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  operand_t   base,
  input  operand_t   exponent,
  input  operand_t   modulus,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output operand_t   result
);

  operand_t         b_op;
  operand_t         e_sh;
  operand_t         m_op;
  operand_t         acc;
  operand_t         sq;
  operand_t         mplier;
  operand_t         mcand;
  operand_t         product;
  logic [CNT_W-1:0] bit_cnt;
  logic             exp_zero;
  logic             mul_busy;
  logic             mul_done;

  // Reducing the base is a multiplication by one, which is zero for a modulus of one.
  always_comb begin
    case (cmd.mul_op)
      OP_REDUCE: begin
        mplier = b_op;
        mcand  = (m_op == OPERAND_WIDTH'(1)) ? '0 : OPERAND_WIDTH'(1);
      end
      OP_ACC: begin
        mplier = acc;
        mcand  = sq;
      end
      OP_SQ: begin
        mplier = sq;
        mcand  = sq;
      end
      default: begin
        mplier = '0;
        mcand  = '0;
      end
    endcase
  end

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .mplier  (mplier),
    .mcand   (mcand),
    .modulus (m_op),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_cnt <= '0;
    end else if (cmd.load) begin
      bit_cnt <= '0;
    end else if (cmd.shift_exp) begin
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b_op     <= base;
      e_sh     <= exponent;
      m_op     <= modulus;
      exp_zero <= (exponent == '0);
    end else if (cmd.shift_exp) begin
      e_sh <= e_sh >> 1;
    end
    if (cmd.load) begin
      acc <= OPERAND_WIDTH'(1);
    end else if (cmd.clear_acc) begin
      acc <= '0;
    end else if (cmd.wr_acc) begin
      acc <= product;
    end
    if (cmd.wr_sq) begin
      sq <= product;
    end
    if (cmd.load_out) begin
      result <= acc;
    end
  end

  always_comb begin
    status.mul_done = mul_done;
    status.mul_busy = mul_busy;
    status.exp_bit  = e_sh[0];
    status.last_bit = (bit_cnt == CNT_W'(OPERAND_WIDTH - 1));
    status.exp_zero = exp_zero;
    status.mod_zero = (m_op == '0);
  end

endmodule

// File: rtl/mexp_ctrl.sv
// Sequencer for the square-and-multiply schedule and the output handshake.
module mexp_ctrl import mexp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output logic       in_stall,
  output logic       out_valid,
  output dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CHECK  = 7'b0000010,
    S_REDUCE = 7'b0000100,
    S_BIT    = 7'b0001000,
    S_MULACC = 7'b0010000,
    S_SQUARE = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.exp_zero) begin
          state_next = S_FINISH;
        end else if (status.mod_zero) begin
          cmd.clear_acc = 1'b1;
          state_next    = S_FINISH;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = OP_REDUCE;
          state_next    = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (status.mul_done) begin
          cmd.wr_sq  = 1'b1;
          state_next = S_BIT;
        end
      end
      S_BIT: begin
        if (status.exp_bit) begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = OP_ACC;
          state_next    = S_MULACC;
        end else if (status.last_bit) begin
          state_next = S_FINISH;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_op    = OP_SQ;
          state_next    = S_SQUARE;
        end
      end
      S_MULACC: begin
        if (status.mul_done) begin
          cmd.wr_acc = 1'b1;
          if (status.last_bit) begin
            state_next = S_FINISH;
          end else begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = OP_SQ;
            state_next    = S_SQUARE;
          end
        end
      end
      S_SQUARE: begin
        if (status.mul_done) begin
          cmd.wr_sq     = 1'b1;
          cmd.shift_exp = 1'b1;
          state_next    = S_BIT;
        end
      end
      S_FINISH: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

// File: rtl/modular_exponentiation_unit.sv
// Modular exponentiation unit. Each input word carries a base, an exponent and a
// modulus; the unit returns one result word holding base to the power exponent,
// reduced by the modulus, computed by right-to-left binary square-and-multiply.
// An exponent of zero always returns 1 (also for a modulus of one), and a modulus
// of zero with a nonzero exponent returns 0. The unit works on one word at a time
// and all arithmetic runs through a single bit-serial modular multiplier, so that
// multiplier sets the rate: a word with a nonzero exponent and nonzero modulus
// occupies the unit for longer the more one bits its exponent holds, while a zero
// exponent or zero modulus finishes without any multiplication. The finished
// result sits in an output register, so the next input word is taken while the
// previous result still waits on a stalled output.
module modular_exponentiation_unit import mexp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  operand_t base,
  input  operand_t exponent,
  input  operand_t modulus,
  output logic     out_valid,
  input  logic     out_stall,
  output operand_t result
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller decides the schedule of multiplications from the status bits
  // of the datapath; the datapath holds every operand and the result register.
  mexp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mexp_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .base     (base),
    .exponent (exponent),
    .modulus  (modulus),
    .cmd      (cmd),
    .status   (status),
    .result   (result)
  );

`include "modular_exponentiation_unit_assert.svh"

  // A new product must never be started while the multiplier is still iterating.
  `MEXP_ASSERT_NOW(a_no_overlap, cmd.mul_start, !status.mul_busy,
                   "multiplier restarted while busy")

  // The output register is only overwritten once its previous word has left.
  `MEXP_ASSERT_NOW(a_no_overwrite, cmd.load_out, !(out_valid && out_stall),
                   "result overwritten")

  // A zero exponent gives exactly one.
  `MEXP_ASSERT_NEXT(a_exp_zero, cmd.load_out && status.exp_zero,
                    result == OPERAND_WIDTH'(1), "zero exponent result is not one")

  // A zero modulus with a nonzero exponent gives zero.
  `MEXP_ASSERT_NEXT(a_mod_zero, cmd.load_out && status.mod_zero && !status.exp_zero,
                    result == '0, "zero modulus result is not zero")

endmodule
